FILE: rtl/core/ffbt_pkg.sv
// Shared types and constants of the first-fit boundary-tag allocator.
`timescale 1ns / 1ps
package ffbt_pkg;

  localparam int unsigned ADDR_W = 24;
  localparam int unsigned SPAN_W = 17;
  localparam int unsigned OFF_W  = 18;
  localparam int unsigned XW     = 28;
  localparam int unsigned OP_W   = 2;
  localparam int unsigned CFG_AW = 3;
  localparam int unsigned CFG_DW = 32;

  localparam int unsigned HEAP_BYTES_DEF = 65536;
  localparam int unsigned PAGE_BYTES_DEF = 16384;
  localparam int unsigned HDR_BYTES      = 8;
  localparam int unsigned MIN_TAIL       = 10;

  localparam logic [OP_W-1:0] OP_ALLOC  = 2'd0;
  localparam logic [OP_W-1:0] OP_FREE   = 2'd1;
  localparam logic [OP_W-1:0] OP_RESIZE = 2'd2;

  localparam logic REG_BASE = 1'b0;
  localparam logic REG_SIZE = 1'b1;

  typedef struct packed {
    logic [SPAN_W-1:0] span;
    logic [SPAN_W-1:0] used;
  } hdr_t;

  typedef struct packed {
    logic [ADDR_W-1:0] heap_base;
    logic [SPAN_W-1:0] heap_size;
  } cfg_t;

endpackage

FILE: rtl/core/ffbt_req_if.sv
// Request channel of the allocator.
`timescale 1ns / 1ps
interface ffbt_req_if;
  import ffbt_pkg::*;
  logic              valid;
  logic              ready;
  logic [OP_W-1:0]   op;
  logic [ADDR_W-1:0] block_address;
  logic [ADDR_W-1:0] request_size;
  logic              page_limited;

  modport source (output valid, op, block_address, request_size, page_limited, input ready);
  modport sink (input valid, op, block_address, request_size, page_limited, output ready);
endinterface

FILE: rtl/core/ffbt_rsp_if.sv
// Response channel of the allocator.
`timescale 1ns / 1ps
interface ffbt_rsp_if;
  import ffbt_pkg::*;
  logic              valid;
  logic              ready;
  logic [ADDR_W-1:0] result_address;
  logic              failed;
  logic [ADDR_W-1:0] copy_source;
  logic [SPAN_W-1:0] copy_length;

  modport source (output valid, result_address, failed, copy_source, copy_length, input ready);
  modport sink (input valid, result_address, failed, copy_source, copy_length, output ready);
endinterface

FILE: rtl/core/ffbt_cfg.sv
// APB register file holding the heap base and size.
`timescale 1ns / 1ps
module ffbt_cfg (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [ffbt_pkg::CFG_AW-1:0]   paddr,
  input  logic [ffbt_pkg::CFG_DW-1:0]   pwdata,
  output logic [ffbt_pkg::CFG_DW-1:0]   prdata,
  output logic                          pready,
  output ffbt_pkg::cfg_t                cfg_o
);
  import ffbt_pkg::*;

  cfg_t cfg_q, cfg_d;
  logic wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      case (paddr[2])
        REG_BASE: cfg_d.heap_base = pwdata[ADDR_W-1:0];
        REG_SIZE: cfg_d.heap_size = pwdata[SPAN_W-1:0];
        default:  cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  always_comb begin
    case (paddr[2])
      REG_BASE: prdata = CFG_DW'(cfg_q.heap_base);
      REG_SIZE: prdata = CFG_DW'(cfg_q.heap_size);
      default:  prdata = '0;
    endcase
  end

  assign cfg_o = cfg_q;

endmodule

FILE: rtl/core/ffbt_hdr_mem.sv
// Header store: one write port, one registered read port with write forwarding.
`timescale 1ns / 1ps
module ffbt_hdr_mem #(
  parameter int unsigned DEPTH = ffbt_pkg::HEAP_BYTES_DEF / 2,
  parameter int unsigned IW    = $clog2(ffbt_pkg::HEAP_BYTES_DEF / 2)
) (
  input  logic                 clk_i,
  input  logic                 we_i,
  input  logic [IW-1:0]        waddr_i,
  input  ffbt_pkg::hdr_t       wdata_i,
  input  logic                 re_i,
  input  logic [IW-1:0]        raddr_i,
  output ffbt_pkg::hdr_t       rdata_o
);
  import ffbt_pkg::*;

  hdr_t mem [DEPTH];
  hdr_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // A read of the entry being written returns the new header.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      if (we_i && (waddr_i == raddr_i)) begin
        rdata_q <= wdata_i;
      end else begin
        rdata_q <= mem[raddr_i];
      end
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: rtl/core/ffbt_seq.sv
// Sequencer: walks and rewrites the block headers for each request.
`timescale 1ns / 1ps
module ffbt_seq #(
  parameter int unsigned HEAP_BYTES = ffbt_pkg::HEAP_BYTES_DEF,
  parameter int unsigned PAGE_BYTES = ffbt_pkg::PAGE_BYTES_DEF,
  parameter int unsigned IW         = $clog2(ffbt_pkg::HEAP_BYTES_DEF / 2)
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  ffbt_req_if.sink             req_i,
  ffbt_rsp_if.source           rsp_o,
  input  ffbt_pkg::cfg_t       cfg_i,
  output logic                 mem_we_o,
  output logic [IW-1:0]        mem_waddr_o,
  output ffbt_pkg::hdr_t       mem_wdata_o,
  output logic                 mem_re_o,
  output logic [IW-1:0]        mem_raddr_o,
  input  ffbt_pkg::hdr_t       mem_rdata_i
);
  import ffbt_pkg::*;

  localparam logic [XW-1:0] PAGE  = XW'(PAGE_BYTES);
  localparam logic [XW-1:0] PMASK = XW'(PAGE_BYTES - 1);
  localparam logic [XW-1:0] HEAPX = XW'(HEAP_BYTES);
  localparam logic [XW-1:0] HDR   = XW'(HDR_BYTES);
  localparam logic [XW-1:0] TAILX = XW'(MIN_TAIL);

  localparam logic [4:0] S_IDLE     = 5'd0;
  localparam logic [4:0] S_DEC      = 5'd1;
  localparam logic [4:0] S_AL_START = 5'd2;
  localparam logic [4:0] S_AL_SETUP = 5'd3;
  localparam logic [4:0] S_AL_C1    = 5'd4;
  localparam logic [4:0] S_AL_C2    = 5'd5;
  localparam logic [4:0] S_AL_C3    = 5'd6;
  localparam logic [4:0] S_FN_A     = 5'd7;
  localparam logic [4:0] S_FN_B     = 5'd8;
  localparam logic [4:0] S_FN_C     = 5'd9;
  localparam logic [4:0] S_RL_A     = 5'd10;
  localparam logic [4:0] S_RL_B     = 5'd11;
  localparam logic [4:0] S_FP_CHK   = 5'd12;
  localparam logic [4:0] S_FP_MRG   = 5'd13;
  localparam logic [4:0] S_RZ_A     = 5'd14;
  localparam logic [4:0] S_RZ_B     = 5'd15;
  localparam logic [4:0] S_OUT      = 5'd16;

  function automatic logic [IW-1:0] idx(input logic [SPAN_W-1:0] off);
    return IW'(off >> 1);
  endfunction

  logic [4:0]        state_q, state_d;
  logic [OP_W-1:0]   op_q, op_d;
  logic [ADDR_W-1:0] addr_q, addr_d;
  logic [ADDR_W-1:0] req_q, req_d;
  logic              pl_q, pl_d;
  logic [ADDR_W:0]   size_q, size_d;
  logic              mv_q, mv_d;
  logic              ready_q, ready_d;
  logic              usable_q, usable_d;
  logic [ADDR_W-1:0] start_q, start_d;
  logic [SPAN_W-1:0] len_q, len_d;
  logic [SPAN_W-1:0] b_q, b_d;
  logic [SPAN_W-1:0] off_q, off_d;
  logic [SPAN_W-1:0] at_q, at_d;
  logic [SPAN_W-1:0] s_q, s_d;
  logic [SPAN_W-1:0] sq_q, sq_d;
  logic [SPAN_W-1:0] tail_q, tail_d;
  logic [SPAN_W-1:0] rest_q, rest_d;
  logic              usedz_q, usedz_d;
  logic              cross_q, cross_d;
  logic [XW-1:0]     blk_q, blk_d;
  logic [XW-1:0]     end_q, end_d;
  logic [XW-1:0]     dst_q, dst_d;
  logic [XW-1:0]     pre_q, pre_d;
  logic [ADDR_W-1:0] res_q, res_d;
  logic              failed_q, failed_d;
  logic [ADDR_W-1:0] csrc_q, csrc_d;
  logic [SPAN_W-1:0] clen_q, clen_d;
  logic              ov_q, ov_d;
  logic [ADDR_W-1:0] o_res_q, o_res_d;
  logic              o_failed_q, o_failed_d;
  logic [ADDR_W-1:0] o_csrc_q, o_csrc_d;
  logic [SPAN_W-1:0] o_clen_q, o_clen_d;

  assign req_i.ready          = (state_q == S_IDLE);
  assign rsp_o.valid          = ov_q;
  assign rsp_o.result_address = o_res_q;
  assign rsp_o.failed         = o_failed_q;
  assign rsp_o.copy_source    = o_csrc_q;
  assign rsp_o.copy_length    = o_clen_q;

  always_comb begin
    logic [XW-1:0]    o_x, l1, lim, want, pre0, sum, cap;
    logic [OFF_W-1:0] n;
    logic             blk_ok, fin;
    hdr_t             rd;

    rd     = mem_rdata_i;
    o_x    = '0;
    l1     = '0;
    lim    = '0;
    want   = '0;
    pre0   = '0;
    sum    = '0;
    cap    = '0;
    n      = '0;
    blk_ok = 1'b0;
    fin    = 1'b0;

    state_d  = state_q;
    op_d     = op_q;
    addr_d   = addr_q;
    req_d    = req_q;
    pl_d     = pl_q;
    size_d   = size_q;
    mv_d     = mv_q;
    ready_d  = ready_q;
    usable_d = usable_q;
    start_d  = start_q;
    len_d    = len_q;
    b_d      = b_q;
    off_d    = off_q;
    at_d     = at_q;
    s_d      = s_q;
    sq_d     = sq_q;
    tail_d   = tail_q;
    rest_d   = rest_q;
    usedz_d  = usedz_q;
    cross_d  = cross_q;
    blk_d    = blk_q;
    end_d    = end_q;
    dst_d    = dst_q;
    pre_d    = pre_q;
    res_d    = res_q;
    failed_d = failed_q;
    csrc_d   = csrc_q;
    clen_d   = clen_q;
    ov_d       = ov_q;
    o_res_d    = o_res_q;
    o_failed_d = o_failed_q;
    o_csrc_d   = o_csrc_q;
    o_clen_d   = o_clen_q;

    mem_we_o    = 1'b0;
    mem_waddr_o = '0;
    mem_wdata_o = '0;
    mem_re_o    = 1'b0;
    mem_raddr_o = '0;

    if (ov_q && rsp_o.ready) begin
      ov_d = 1'b0;
    end

    case (state_q)
      S_IDLE: begin
        if (req_i.valid) begin
          op_d     = req_i.op;
          addr_d   = req_i.block_address;
          req_d    = req_i.request_size;
          pl_d     = req_i.page_limited;
          mv_d     = 1'b0;
          res_d    = '0;
          failed_d = 1'b0;
          csrc_d   = '0;
          clen_d   = '0;
          state_d  = S_DEC;
        end
      end

      S_DEC: begin
        size_d = (ADDR_W + 1)'({1'b0, req_q} + 1'b1) & ~(ADDR_W + 1)'(1);
        o_x    = XW'(addr_q) - XW'(start_q) - HDR;
        blk_ok = usable_q && (XW'(addr_q) >= XW'(start_q) + HDR) && !o_x[0]
                 && (o_x < XW'(len_q));
        off_d  = o_x[SPAN_W-1:0];
        case (op_q)
          OP_ALLOC: state_d = S_AL_START;
          OP_FREE: begin
            if ((addr_q != '0) && blk_ok) begin
              mem_re_o    = 1'b1;
              mem_raddr_o = idx(o_x[SPAN_W-1:0]);
              state_d     = S_RL_A;
            end else begin
              state_d = S_OUT;
            end
          end
          OP_RESIZE: begin
            if (addr_q == '0) begin
              state_d = S_AL_START;
            end else if (!blk_ok) begin
              failed_d = (req_q != '0);
              state_d  = S_OUT;
            end else begin
              mem_re_o    = 1'b1;
              mem_raddr_o = idx(o_x[SPAN_W-1:0]);
              state_d     = (req_q == '0) ? S_RL_A : S_RZ_A;
            end
          end
          default: state_d = S_OUT;
        endcase
      end

      S_AL_START: begin
        if (req_q == '0) begin
          state_d = S_OUT;
        end else if (pl_q && (XW'(size_q) + HDR > PAGE)) begin
          failed_d = 1'b1;
          state_d  = S_OUT;
        end else if (!ready_q) begin
          // Latch the heap geometry once, capped at the store and the address space.
          ready_d = 1'b1;
          start_d = {cfg_i.heap_base[ADDR_W-1:1], 1'b0};
          l1      = XW'(cfg_i.heap_size);
          if (l1 > HEAPX) begin
            l1 = HEAPX;
          end
          lim = (XW'(1) << ADDR_W) - XW'({cfg_i.heap_base[ADDR_W-1:1], 1'b0});
          if (l1 > lim) begin
            l1 = lim;
          end
          len_d    = {l1[SPAN_W-1:1], 1'b0};
          usable_d = (XW'({l1[SPAN_W-1:1], 1'b0}) >= TAILX);
          state_d  = S_AL_SETUP;
        end else if (usable_q) begin
          b_d         = '0;
          mem_re_o    = 1'b1;
          mem_raddr_o = idx('0);
          state_d     = S_AL_C1;
        end else begin
          failed_d = 1'b1;
          state_d  = S_OUT;
        end
      end

      S_AL_SETUP: begin
        if (usable_q) begin
          mem_we_o    = 1'b1;
          mem_waddr_o = idx('0);
          mem_wdata_o = '{span: len_q, used: '0};
          b_d         = '0;
          mem_re_o    = 1'b1;
          mem_raddr_o = idx('0);
          state_d     = S_AL_C1;
        end else begin
          failed_d = 1'b1;
          state_d  = S_OUT;
        end
      end

      S_AL_C1: begin
        s_d     = rd.span;
        usedz_d = (rd.used == '0);
        blk_d   = XW'(start_q) + XW'(b_q);
        end_d   = XW'(start_q) + XW'(b_q) + XW'(rd.span);
        cross_d = pl_q && ((((XW'(start_q) + XW'(b_q) + HDR) & PMASK) + XW'(size_q)) > PAGE);
        dst_d   = (XW'(start_q) + XW'(b_q) + PAGE) & ~PMASK;
        state_d = S_AL_C2;
      end

      S_AL_C2: begin
        pre0 = dst_q - blk_q;
        if (!cross_q) begin
          dst_d = blk_q;
          pre_d = '0;
        end else if (pre0 < HDR) begin
          dst_d = dst_q + PAGE;
          pre_d = pre0 + PAGE;
        end else begin
          pre_d = pre0;
        end
        state_d = S_AL_C3;
      end

      S_AL_C3: begin
        if (usedz_q && (dst_q + HDR + XW'(size_q) <= end_q)) begin
          at_d = b_q + pre_q[SPAN_W-1:0];
          if (pre_q != '0) begin
            // The gap in front of the page boundary stays a free block.
            mem_we_o    = 1'b1;
            mem_waddr_o = idx(b_q);
            mem_wdata_o = '{span: pre_q[SPAN_W-1:0], used: '0};
            sum         = end_q - dst_q;
            sq_d        = sum[SPAN_W-1:0];
          end else begin
            sq_d = s_q;
          end
          res_d   = ADDR_W'(XW'(start_q) + XW'(b_q + pre_q[SPAN_W-1:0]) + HDR);
          state_d = S_FN_A;
        end else begin
          n = {1'b0, b_q} + {1'b0, s_q};
          if ((s_q == '0) || (n >= {1'b0, len_q})) begin
            failed_d = 1'b1;
            res_d    = '0;
            state_d  = S_OUT;
          end else begin
            b_d         = n[SPAN_W-1:0];
            mem_re_o    = 1'b1;
            mem_raddr_o = idx(n[SPAN_W-1:0]);
            state_d     = S_AL_C1;
          end
        end
      end

      S_FN_A: begin
        want = XW'(size_q) + HDR;
        if ((XW'(sq_q) >= want) && (XW'(sq_q) - want >= TAILX)) begin
          sum         = XW'(sq_q) - want;
          rest_d      = sum[SPAN_W-1:0];
          tail_d      = at_q + want[SPAN_W-1:0];
          mem_we_o    = 1'b1;
          mem_waddr_o = idx(at_q + want[SPAN_W-1:0]);
          mem_wdata_o = '{span: sum[SPAN_W-1:0], used: '0};
          state_d     = S_FN_B;
        end else begin
          mem_we_o    = 1'b1;
          mem_waddr_o = idx(at_q);
          mem_wdata_o = '{span: sq_q, used: req_q[SPAN_W-1:0]};
          fin         = 1'b1;
        end
      end

      S_FN_B: begin
        want        = XW'(size_q) + HDR;
        mem_we_o    = 1'b1;
        mem_waddr_o = idx(at_q);
        mem_wdata_o = '{span: want[SPAN_W-1:0], used: req_q[SPAN_W-1:0]};
        n           = {1'b0, tail_q} + {1'b0, rest_q};
        if (n < {1'b0, len_q}) begin
          mem_re_o    = 1'b1;
          mem_raddr_o = idx(n[SPAN_W-1:0]);
          state_d     = S_FN_C;
        end else begin
          fin = 1'b1;
        end
      end

      S_FN_C: begin
        if (rd.used == '0) begin
          mem_we_o    = 1'b1;
          mem_waddr_o = idx(tail_q);
          mem_wdata_o = '{span: rest_q + rd.span, used: '0};
        end
        fin = 1'b1;
      end

      S_RL_A: begin
        if (mv_q) begin
          csrc_d = addr_q;
          clen_d = (XW'(rd.used) < XW'(req_q)) ? rd.used : req_q[SPAN_W-1:0];
        end
        s_d = rd.span;
        n   = {1'b0, off_q} + {1'b0, rd.span};
        if ((rd.span != '0) && (n < {1'b0, len_q})) begin
          mem_re_o    = 1'b1;
          mem_raddr_o = idx(n[SPAN_W-1:0]);
          state_d     = S_RL_B;
        end else begin
          mem_we_o    = 1'b1;
          mem_waddr_o = idx(off_q);
          mem_wdata_o = '{span: rd.span, used: '0};
          b_d         = '0;
          mem_re_o    = 1'b1;
          mem_raddr_o = idx('0);
          state_d     = S_FP_CHK;
        end
      end

      S_RL_B: begin
        mem_we_o    = 1'b1;
        mem_waddr_o = idx(off_q);
        mem_wdata_o = '{span: (rd.used == '0) ? s_q + rd.span : s_q, used: '0};
        b_d         = '0;
        mem_re_o    = 1'b1;
        mem_raddr_o = idx('0);
        state_d     = S_FP_CHK;
      end

      S_FP_CHK: begin
        // Walk from the heap start to find the block in front of the freed one.
        n = {1'b0, b_q} + {1'b0, rd.span};
        if ((rd.span == '0) || (n >= {1'b0, len_q})) begin
          state_d = S_OUT;
        end else if (n[SPAN_W-1:0] == off_q) begin
          if (rd.used == '0) begin
            s_d         = rd.span;
            mem_re_o    = 1'b1;
            mem_raddr_o = idx(off_q);
            state_d     = S_FP_MRG;
          end else begin
            state_d = S_OUT;
          end
        end else begin
          b_d         = n[SPAN_W-1:0];
          mem_re_o    = 1'b1;
          mem_raddr_o = idx(n[SPAN_W-1:0]);
        end
      end

      S_FP_MRG: begin
        if (rd.used == '0) begin
          mem_we_o    = 1'b1;
          mem_waddr_o = idx(b_q);
          mem_wdata_o = '{span: s_q + rd.span, used: '0};
        end
        state_d = S_OUT;
      end

      S_RZ_A: begin
        s_d = rd.span;
        cap = (XW'(rd.span) >= HDR) ? XW'(rd.span) - HDR : '0;
        n   = {1'b0, off_q} + {1'b0, rd.span};
        if (XW'(size_q) <= cap) begin
          sq_d    = rd.span;
          at_d    = off_q;
          res_d   = addr_q;
          state_d = S_FN_A;
        end else if ((rd.span != '0) && (n < {1'b0, len_q})) begin
          mem_re_o    = 1'b1;
          mem_raddr_o = idx(n[SPAN_W-1:0]);
          state_d     = S_RZ_B;
        end else begin
          mv_d    = 1'b1;
          state_d = S_AL_START;
        end
      end

      S_RZ_B: begin
        sum = XW'(s_q) + XW'(rd.span);
        if ((rd.used == '0) && (sum >= XW'(size_q) + HDR)
            && (!pl_q || ((XW'(addr_q) & PMASK) + XW'(size_q) <= PAGE))) begin
          sq_d    = sum[SPAN_W-1:0];
          at_d    = off_q;
          res_d   = addr_q;
          state_d = S_FN_A;
        end else begin
          mv_d    = 1'b1;
          state_d = S_AL_START;
        end
      end

      S_OUT: begin
        if (!ov_q || rsp_o.ready) begin
          ov_d       = 1'b1;
          o_res_d    = res_q;
          o_failed_d = failed_q;
          o_csrc_d   = csrc_q;
          o_clen_d   = clen_q;
          state_d    = S_IDLE;
        end
      end

      default: state_d = S_IDLE;
    endcase

    // After placing a block, a moving resize goes on to free the old one.
    if (fin) begin
      if (mv_q) begin
        mem_re_o    = 1'b1;
        mem_raddr_o = idx(off_q);
        state_d     = S_RL_A;
      end else begin
        state_d = S_OUT;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      ready_q  <= 1'b0;
      usable_q <= 1'b0;
      start_q  <= '0;
      len_q    <= '0;
      mv_q     <= 1'b0;
      ov_q     <= 1'b0;
    end else begin
      state_q  <= state_d;
      ready_q  <= ready_d;
      usable_q <= usable_d;
      start_q  <= start_d;
      len_q    <= len_d;
      mv_q     <= mv_d;
      ov_q     <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q       <= op_d;
    addr_q     <= addr_d;
    req_q      <= req_d;
    pl_q       <= pl_d;
    size_q     <= size_d;
    b_q        <= b_d;
    off_q      <= off_d;
    at_q       <= at_d;
    s_q        <= s_d;
    sq_q       <= sq_d;
    tail_q     <= tail_d;
    rest_q     <= rest_d;
    usedz_q    <= usedz_d;
    cross_q    <= cross_d;
    blk_q      <= blk_d;
    end_q      <= end_d;
    dst_q      <= dst_d;
    pre_q      <= pre_d;
    res_q      <= res_d;
    failed_q   <= failed_d;
    csrc_q     <= csrc_d;
    clen_q     <= clen_d;
    o_res_q    <= o_res_d;
    o_failed_q <= o_failed_d;
    o_csrc_q   <= o_csrc_d;
    o_clen_q   <= o_clen_d;
  end

endmodule

FILE: rtl/core/first_fit_boundary_tag_allocator_top.sv
// Allocate walks the block headers from the heap start and may then split the chosen block.
// Release merges a free next block, then walks from the heap start to the block in front of it.
// A moving resize adds a release after its allocate; their duration is set by the header walk
// through the single read port of the header store. One request is in work at a time.
// Reset clears the control state and the heap set-up flags; the header store is not cleared.
// The result waits in an output register, so the next request is taken while it is pending.
`timescale 1ns / 1ps
module first_fit_boundary_tag_allocator_top #(
  parameter int unsigned HEAP_BYTES = ffbt_pkg::HEAP_BYTES_DEF,
  parameter int unsigned PAGE_BYTES = ffbt_pkg::PAGE_BYTES_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  ffbt_req_if.sink                      req_i,
  ffbt_rsp_if.source                    rsp_o,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [ffbt_pkg::CFG_AW-1:0]   paddr,
  input  logic [ffbt_pkg::CFG_DW-1:0]   pwdata,
  output logic [ffbt_pkg::CFG_DW-1:0]   prdata,
  output logic                          pready
);
  import ffbt_pkg::*;

  localparam int unsigned DEPTH = HEAP_BYTES / 2;
  localparam int unsigned IW    = $clog2(HEAP_BYTES / 2);

  cfg_t          cfg;
  logic          mem_we;
  logic [IW-1:0] mem_waddr;
  hdr_t          mem_wdata;
  logic          mem_re;
  logic [IW-1:0] mem_raddr;
  hdr_t          mem_rdata;

  ffbt_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  ffbt_hdr_mem #(
    .DEPTH (DEPTH),
    .IW    (IW)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  ffbt_seq #(
    .HEAP_BYTES (HEAP_BYTES),
    .PAGE_BYTES (PAGE_BYTES),
    .IW         (IW)
  ) u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_i       (req_i),
    .rsp_o       (rsp_o),
    .cfg_i       (cfg),
    .mem_we_o    (mem_we),
    .mem_waddr_o (mem_waddr),
    .mem_wdata_o (mem_wdata),
    .mem_re_o    (mem_re),
    .mem_raddr_o (mem_raddr),
    .mem_rdata_i (mem_rdata)
  );

  // One request at a time: the request side closes right after a transfer.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req_i.valid && req_i.ready) |=> !req_i.ready)
    else $error("request taken while another is in work");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_o.valid && rsp_o.failed) |-> (rsp_o.result_address == '0))
    else $error("failed result carries an address");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_o.valid && (rsp_o.copy_length != '0))
      |-> ((rsp_o.copy_source != '0) && !rsp_o.failed))
    else $error("copy request without source or on failure");

endmodule
